// File: hdl/clock_second_chance_replacer_unit_assert.svh
// Assertion macros for the clock replacement unit
`ifndef CLOCK_SECOND_CHANCE_REPLACER_UNIT_ASSERT_SVH
`define CLOCK_SECOND_CHANCE_REPLACER_UNIT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define CCSR_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ccsr assertion failed");

// next-cycle implication
`define CCSR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ccsr assertion failed");

`endif

// File: hdl/ccsr_pkg.sv
// Package: types and constants of the clock replacement unit
`timescale 1ns / 1ps
package ccsr_pkg;

  localparam int FRAME_COUNT = 1024;
  localparam int FRAME_W     = 10;
  localparam int CMD_W       = 3;
  localparam int QDEPTH      = 2;
  localparam int QPTR_W      = 1;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 3'd0,
    CMD_REMOVE = 3'd1,
    CMD_QUERY  = 3'd2,
    CMD_ACCESS = 3'd3,
    CMD_VICTIM = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    OP_INSERT,
    OP_REMOVE,
    OP_QUERY,
    OP_ACCESS,
    OP_VICTIM,
    OP_NOP
  } op_e;

  typedef enum logic [2:0] {
    STAT_OK     = 3'd0,
    STAT_BAD    = 3'd1,
    STAT_DUP    = 3'd2,
    STAT_ABSENT = 3'd3,
    STAT_EMPTY  = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_WALK,
    ST_LINK2
  } state_e;

  typedef struct packed {
    op_e                op;
    logic               bad;
    logic [FRAME_W-1:0] frame;
    logic               wr;
  } item_t;

  typedef struct packed {
    logic               in_ring;
    logic               acc;
    logic               dirty;
  } flags_t;

  typedef struct packed {
    logic               ring_empty;
    logic               evict_dirty;
    logic [FRAME_W-1:0] result_frame;
    logic               present;
    status_e            status;
  } res_t;

  typedef struct packed {
    logic  head_valid;
    item_t head;
  } qhead_t;

endpackage

// File: hdl/clock_second_chance_replacer_unit.sv
// Top level of the clock (second chance) page replacement unit
`timescale 1ns / 1ps
// Commands enter a two-word queue and run one at a time against link and
// flag memories that each have one read port and one write port. After
// reset a clearing pass writes all 1024 flag entries with s_axis_tready low.
// Query, access and failing commands finish in the check state; insert and
// remove walk the ring from the hand one link per cycle, and a victim sweep
// visits one frame per cycle. The queue still takes commands while a result
// waits, but no new command starts until the result is taken.
module clock_second_chance_replacer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // cmd[2:0], frame[12:3], write_access[13]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata   // status[2:0], present[3], result_frame[13:4],
                                     // evict_dirty[14], ring_empty[15]
);
  import ccsr_pkg::*;

  qhead_t qhead;
  logic   pop;
  logic   clearing;
  res_t   res;

  ccsr_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .hold_i        (clearing),
    .pop_i         (pop),
    .qhead_o       (qhead)
  );

  ccsr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .qhead_i     (qhead),
    .pop_o       (pop),
    .clearing_o  (clearing),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  assign m_axis_tdata = {res.ring_empty, res.evict_dirty, res.result_frame,
                         res.present, res.status};

`include "clock_second_chance_replacer_unit_assert.svh"

  `CCSR_ASSERT_IMPL(a_no_accept_clear, clearing, !s_axis_tready)
  `CCSR_ASSERT_IMPL(a_pop_has_head, pop, qhead.head_valid)
  `CCSR_ASSERT_IMPL(a_empty_flagged, m_axis_tvalid && res.status == STAT_EMPTY, res.ring_empty)
  `CCSR_ASSERT_NEXT(a_pop_holds_result, pop, !m_axis_tvalid)

endmodule

// File: hdl/ccsr_front.sv
// Front end: accepts command words, decodes them and queues them
`timescale 1ns / 1ps
module ccsr_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [15:0]        s_axis_tdata,
  input  logic               hold_i,
  input  logic               pop_i,
  output ccsr_pkg::qhead_t   qhead_o
);
  import ccsr_pkg::*;

  item_t             q_mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QPTR_W:0]   cnt_q, cnt_d;
  logic              push;
  item_t             item;
  logic [CMD_W-1:0]  cmd;

  assign cmd = s_axis_tdata[CMD_W-1:0];

  always_comb begin
    item.frame = s_axis_tdata[CMD_W+FRAME_W-1:CMD_W];
    item.wr    = s_axis_tdata[CMD_W+FRAME_W];
    unique case (cmd)
      CMD_INSERT: item.op = OP_INSERT;
      CMD_REMOVE: item.op = OP_REMOVE;
      CMD_QUERY:  item.op = OP_QUERY;
      CMD_ACCESS: item.op = OP_ACCESS;
      CMD_VICTIM: item.op = OP_VICTIM;
      default:    item.op = OP_NOP;
    endcase
    item.bad = (item.op != OP_VICTIM) && (item.op != OP_NOP) &&
               ({1'b0, item.frame} >= (FRAME_W+1)'(FRAME_COUNT));
  end

  assign s_axis_tready = (cnt_q < (QPTR_W+1)'(QDEPTH)) && !hold_i;
  assign push          = s_axis_tvalid && s_axis_tready;

  always_comb begin
    wr_ptr_d = wr_ptr_q + QPTR_W'(push);
    rd_ptr_d = rd_ptr_q + QPTR_W'(pop_i);
    cnt_d    = cnt_q + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_ptr_q] <= item;
    end
  end

  assign qhead_o.head_valid = (cnt_q != '0);
  assign qhead_o.head       = q_mem_q[rd_ptr_q];

endmodule

// File: hdl/ccsr_back.sv
// Back end: ring walker with link and flag memories and result register
`timescale 1ns / 1ps
module ccsr_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ccsr_pkg::qhead_t qhead_i,
  output logic             pop_o,
  output logic             clearing_o,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output ccsr_pkg::res_t   res_o
);
  import ccsr_pkg::*;

  logic [2:0]         flags_mem [FRAME_COUNT];
  logic [FRAME_W-1:0] link_mem  [FRAME_COUNT];

  state_e             state_q, state_d;
  logic [FRAME_W-1:0] clr_q, clr_d;
  logic [FRAME_W-1:0] hand_q, hand_d;
  logic               empty_q, empty_d;
  item_t              cur_q, cur_d;
  logic [FRAME_W-1:0] p_q, p_d;
  logic [FRAME_W-1:0] s_q, s_d;
  logic               out_valid_q, out_valid_d;
  res_t               out_q, out_d;

  logic [2:0]         flags_rd_q;
  logic [FRAME_W-1:0] link_rd_q;
  flags_t             fl;
  logic [FRAME_W-1:0] rd_addr;
  logic               flags_we, link_we;
  logic [FRAME_W-1:0] flags_waddr, link_waddr, link_wdata;
  flags_t             flags_wdata;
  logic [FRAME_W-1:0] target;
  logic               walk_hit, fin;
  status_e            fin_status;

  assign fl       = flags_t'(flags_rd_q);
  assign target   = (cur_q.op == OP_INSERT) ? hand_q : cur_q.frame;
  assign walk_hit = (link_rd_q == target);
  assign pop_o    = (state_q == ST_IDLE) && qhead_i.head_valid && !out_valid_q;
  assign clearing_o = (state_q == ST_CLEAR);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_q == FRAME_W'(FRAME_COUNT - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (pop_o) state_d = ST_CHECK;
      end
      ST_CHECK: begin
        state_d = ST_IDLE;
        if (!cur_q.bad) begin
          if (cur_q.op == OP_INSERT && !fl.in_ring && !empty_q) state_d = ST_WALK;
          if (cur_q.op == OP_REMOVE && fl.in_ring && link_rd_q != cur_q.frame) begin
            state_d = ST_WALK;
          end
          if (cur_q.op == OP_VICTIM && !empty_q && fl.acc && link_rd_q != hand_q) begin
            state_d = ST_CHECK;
          end
        end
      end
      ST_WALK: begin
        if (walk_hit) state_d = (cur_q.op == OP_INSERT) ? ST_LINK2 : ST_IDLE;
      end
      ST_LINK2: state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    clr_d       = clr_q;
    hand_d      = hand_q;
    empty_d     = empty_q;
    cur_d       = cur_q;
    p_d         = p_q;
    s_d         = s_q;
    out_valid_d = out_valid_q && !res_ready_i;
    out_d       = out_q;
    rd_addr     = hand_q;
    flags_we    = 1'b0;
    flags_waddr = cur_q.frame;
    flags_wdata = '0;
    link_we     = 1'b0;
    link_waddr  = cur_q.frame;
    link_wdata  = hand_q;
    fin         = 1'b0;
    fin_status  = STAT_OK;
    out_d.present      = 1'b0;
    out_d.result_frame = '0;
    out_d.evict_dirty  = 1'b0;
    out_d.ring_empty   = out_q.ring_empty;
    out_d.status       = out_q.status;
    unique case (state_q)
      ST_CLEAR: begin
        flags_we    = 1'b1;
        flags_waddr = clr_q;
        clr_d       = clr_q + FRAME_W'(1);
      end
      ST_IDLE: begin
        cur_d   = qhead_i.head;
        rd_addr = (qhead_i.head.op == OP_VICTIM) ? hand_q : qhead_i.head.frame;
      end
      ST_CHECK: begin
        if (cur_q.bad) begin
          fin        = 1'b1;
          fin_status = STAT_BAD;
        end else begin
          unique case (cur_q.op)
            OP_INSERT: begin
              if (fl.in_ring) begin
                fin        = 1'b1;
                fin_status = STAT_DUP;
              end else begin
                flags_we    = 1'b1;
                flags_wdata = '{in_ring: 1'b1, acc: 1'b0, dirty: 1'b0};
                if (empty_q) begin
                  link_we    = 1'b1;
                  link_wdata = cur_q.frame;
                  hand_d     = cur_q.frame;
                  empty_d    = 1'b0;
                  fin        = 1'b1;
                end else begin
                  p_d     = hand_q;
                  rd_addr = hand_q;
                end
              end
            end
            OP_REMOVE: begin
              if (!fl.in_ring) begin
                fin        = 1'b1;
                fin_status = STAT_ABSENT;
              end else begin
                flags_we = 1'b1;
                s_d      = link_rd_q;
                if (link_rd_q == cur_q.frame) begin
                  hand_d  = '0;
                  empty_d = 1'b1;
                  fin     = 1'b1;
                end else begin
                  p_d     = hand_q;
                  rd_addr = hand_q;
                end
              end
            end
            OP_QUERY: begin
              fin           = 1'b1;
              out_d.present = fl.in_ring;
            end
            OP_ACCESS: begin
              fin = 1'b1;
              if (!fl.in_ring) begin
                fin_status = STAT_ABSENT;
              end else begin
                flags_we    = 1'b1;
                flags_wdata = '{in_ring: 1'b1, acc: 1'b1, dirty: fl.dirty | cur_q.wr};
              end
            end
            OP_VICTIM: begin
              flags_waddr = hand_q;
              if (empty_q) begin
                fin        = 1'b1;
                fin_status = STAT_EMPTY;
              end else if (fl.acc && link_rd_q != hand_q) begin
                flags_we    = 1'b1;
                flags_wdata = '{in_ring: 1'b1, acc: 1'b0, dirty: fl.dirty};
                hand_d      = link_rd_q;
                rd_addr     = link_rd_q;
              end else begin
                flags_we           = 1'b1;
                flags_wdata        = '{in_ring: 1'b1, acc: 1'b0, dirty: 1'b0};
                out_d.result_frame = hand_q;
                out_d.evict_dirty  = fl.dirty;
                hand_d             = link_rd_q;
                fin                = 1'b1;
              end
            end
            default: fin = 1'b1;
          endcase
        end
      end
      ST_WALK: begin
        if (walk_hit) begin
          link_we    = 1'b1;
          link_waddr = p_q;
          if (cur_q.op == OP_INSERT) begin
            link_wdata = cur_q.frame;
          end else begin
            link_wdata         = s_q;
            hand_d             = s_q;
            out_d.result_frame = s_q;
            fin                = 1'b1;
          end
        end else begin
          p_d     = link_rd_q;
          rd_addr = link_rd_q;
        end
      end
      ST_LINK2: begin
        link_we    = 1'b1;
        link_waddr = cur_q.frame;
        link_wdata = hand_q;
        fin        = 1'b1;
      end
      default: ;
    endcase
    if (fin) begin
      out_valid_d      = 1'b1;
      out_d.status     = fin_status;
      out_d.ring_empty = empty_d;
    end else begin
      out_d.present      = out_q.present;
      out_d.result_frame = out_q.result_frame;
      out_d.evict_dirty  = out_q.evict_dirty;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      hand_q      <= '0;
      empty_q     <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      hand_q      <= hand_d;
      empty_q     <= empty_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    p_q   <= p_d;
    s_q   <= s_d;
    out_q <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (flags_we) flags_mem[flags_waddr] <= flags_wdata;
    flags_rd_q <= flags_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (link_we) link_mem[link_waddr] <= link_wdata;
    link_rd_q <= link_mem[rd_addr];
  end

  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

endmodule
